// ===== src/midi_event_serializer_assert.svh =====
// Assertion macros for the MIDI event serializer.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef MIDI_EVENT_SERIALIZER_ASSERT_SVH
`define MIDI_EVENT_SERIALIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a condition that must follow another in the same cycle.
`define MES_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("serializer assertion failed");
// Check a condition that must hold in the cycle after another.
`define MES_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("serializer assertion failed");
`else
`define MES_ASSERT_SAME(label, pre, post)
`define MES_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== src/mes_pkg.sv =====
// Shared types, action codes and byte constants for the MIDI event serializer.
// No dependencies; used by every module of the block.
package mes_pkg;

    // Input action codes
    localparam logic [4:0] ACT_KEYON     = 5'd0;
    localparam logic [4:0] ACT_KEYOFF    = 5'd1;
    localparam logic [4:0] ACT_POLYPRESS = 5'd2;
    localparam logic [4:0] ACT_CTRL      = 5'd3;
    localparam logic [4:0] ACT_PROG      = 5'd4;
    localparam logic [4:0] ACT_CHANPRESS = 5'd5;
    localparam logic [4:0] ACT_BEND      = 5'd6;
    localparam logic [4:0] ACT_SONGPOS   = 5'd7;
    localparam logic [4:0] ACT_SONGSEL   = 5'd8;
    localparam logic [4:0] ACT_RT_CLOCK  = 5'd9;
    localparam logic [4:0] ACT_RT_START  = 5'd10;
    localparam logic [4:0] ACT_RT_CONT   = 5'd11;
    localparam logic [4:0] ACT_RT_STOP   = 5'd12;
    localparam logic [4:0] ACT_RT_TUNE   = 5'd13;
    localparam logic [4:0] ACT_RT_SENSE  = 5'd14;
    localparam logic [4:0] ACT_RT_RESET  = 5'd15;
    localparam logic [4:0] ACT_SYSEX     = 5'd16;
    localparam logic [4:0] ACT_STREAM    = 5'd17;
    localparam logic [4:0] ACT_QFRAME    = 5'd18;
    localparam logic [4:0] ACT_CTRL14    = 5'd19;
    localparam logic [4:0] ACT_NRPN      = 5'd20;
    localparam logic [4:0] ACT_RPN       = 5'd21;
    localparam logic [4:0] ACT_DROP      = 5'd22;

    // Channel status high nibbles
    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_POLY      = 4'hA;
    localparam logic [3:0] ST_CTRL      = 4'hB;
    localparam logic [3:0] ST_PROG      = 4'hC;
    localparam logic [3:0] ST_CHANPRESS = 4'hD;
    localparam logic [3:0] ST_BEND      = 4'hE;

    // System bytes
    localparam logic [7:0] SYS_SOX     = 8'hF0;
    localparam logic [7:0] SYS_QFRAME  = 8'hF1;
    localparam logic [7:0] SYS_SONGPOS = 8'hF2;
    localparam logic [7:0] SYS_SONGSEL = 8'hF3;
    localparam logic [7:0] SYS_EOX     = 8'hF7;

    // Controller numbers for parameter messages
    localparam logic [7:0] CC_NRPN_MSB  = 8'h63;
    localparam logic [7:0] CC_NRPN_LSB  = 8'h62;
    localparam logic [7:0] CC_RPN_MSB   = 8'h65;
    localparam logic [7:0] CC_RPN_LSB   = 8'h64;
    localparam logic [7:0] CC_DATA_MSB  = 8'h06;
    localparam logic [7:0] CC_DATA_LSB  = 8'h26;

    localparam int MSG_SLOTS   = 9;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // One classified message: wire bytes in slots, sent from first_idx to last_idx
    typedef struct packed {
        logic [MSG_SLOTS-1:0][7:0] msg_bytes;
        logic [3:0]                first_idx;
        logic [3:0]                last_idx;
        logic [7:0]                port;
    } msg_desc_t;

    // Map a real-time action to its wire byte
    function automatic logic [7:0] rt_code(input logic [4:0] act);
        logic [7:0] code;
        unique case (act)
            ACT_RT_CLOCK: code = 8'hF8;
            ACT_RT_START: code = 8'hFA;
            ACT_RT_CONT:  code = 8'hFB;
            ACT_RT_STOP:  code = 8'hFC;
            ACT_RT_TUNE:  code = 8'hF6;
            ACT_RT_SENSE: code = 8'hFE;
            default:      code = 8'hFF;
        endcase
        return code;
    endfunction

endpackage

// ===== src/mes_front.sv =====
// Front end: accepts events, tracks running status and builds a message descriptor.
// Depends on mes_pkg; feeds mes_queue.
module mes_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [4:0]            action,
    input  logic [3:0]            channel,
    input  logic [7:0]            port_number,
    input  logic [13:0]           value_a,
    input  logic [13:0]           value_b,
    input  logic [7:0]            payload_byte,
    input  logic                  first_of_message,
    input  logic                  last_of_message,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  q_full,
    output logic                  push,
    output mes_pkg::msg_desc_t    desc
);

    localparam logic [3:0] ST_NONE_HI = 4'h0;

    logic       rs_enable_reg;
    logic [7:0] running_status_reg;
    logic [7:0] running_status_next;
    logic       accept;
    logic       has_status;
    logic       emits;
    logic [3:0] status_hi;
    logic [7:0] status;
    logic [4:0] cc_num;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign status    = {status_hi, channel};
    assign cc_num    = value_a[4:0];
    assign push      = accept && emits;

    // Classify the event and lay out its bytes
    always_comb
    begin
        desc                = '0;
        desc.port           = port_number;
        status_hi           = ST_NONE_HI;
        has_status          = 1'b0;
        emits               = 1'b1;
        running_status_next = running_status_reg;
        unique case (action)
            mes_pkg::ACT_KEYON, mes_pkg::ACT_KEYOFF, mes_pkg::ACT_POLYPRESS,
            mes_pkg::ACT_CTRL, mes_pkg::ACT_BEND:
            begin
                unique case (action)
                    mes_pkg::ACT_KEYON:     status_hi = mes_pkg::ST_NOTE_ON;
                    mes_pkg::ACT_KEYOFF:    status_hi = mes_pkg::ST_NOTE_OFF;
                    mes_pkg::ACT_POLYPRESS: status_hi = mes_pkg::ST_POLY;
                    mes_pkg::ACT_CTRL:      status_hi = mes_pkg::ST_CTRL;
                    default:                status_hi = mes_pkg::ST_BEND;
                endcase
                has_status        = 1'b1;
                desc.msg_bytes[1] = {1'b0, value_a[6:0]};
                desc.msg_bytes[2] = {1'b0, value_b[6:0]};
                desc.last_idx     = 4'd2;
            end
            mes_pkg::ACT_PROG, mes_pkg::ACT_CHANPRESS:
            begin
                status_hi         = (action == mes_pkg::ACT_PROG) ? mes_pkg::ST_PROG
                                                                  : mes_pkg::ST_CHANPRESS;
                has_status        = 1'b1;
                desc.msg_bytes[1] = {1'b0, value_a[6:0]};
                desc.last_idx     = 4'd1;
            end
            mes_pkg::ACT_SONGPOS:
            begin
                desc.msg_bytes[0]   = mes_pkg::SYS_SONGPOS;
                desc.msg_bytes[1]   = {1'b0, value_a[6:0]};
                desc.msg_bytes[2]   = {1'b0, value_b[6:0]};
                desc.last_idx       = 4'd2;
                running_status_next = '0;
            end
            mes_pkg::ACT_SONGSEL:
            begin
                desc.msg_bytes[0]   = mes_pkg::SYS_SONGSEL;
                desc.msg_bytes[1]   = {1'b0, value_a[6:0]};
                desc.last_idx       = 4'd1;
                running_status_next = '0;
            end
            mes_pkg::ACT_RT_CLOCK, mes_pkg::ACT_RT_START, mes_pkg::ACT_RT_CONT,
            mes_pkg::ACT_RT_STOP, mes_pkg::ACT_RT_TUNE, mes_pkg::ACT_RT_SENSE,
            mes_pkg::ACT_RT_RESET:
            begin
                desc.msg_bytes[0] = mes_pkg::rt_code(action);
            end
            mes_pkg::ACT_SYSEX:
            begin
                desc.msg_bytes[0]   = mes_pkg::SYS_SOX;
                desc.msg_bytes[1]   = payload_byte;
                desc.msg_bytes[2]   = mes_pkg::SYS_EOX;
                desc.first_idx      = first_of_message ? 4'd0 : 4'd1;
                desc.last_idx       = last_of_message ? 4'd2 : 4'd1;
                running_status_next = '0;
            end
            mes_pkg::ACT_STREAM:
            begin
                desc.msg_bytes[0]   = payload_byte;
                running_status_next = '0;
            end
            mes_pkg::ACT_QFRAME:
            begin
                desc.msg_bytes[0]   = mes_pkg::SYS_QFRAME;
                desc.msg_bytes[1]   = {1'b0, value_a[2:0], value_b[3:0]};
                desc.last_idx       = 4'd1;
                running_status_next = '0;
            end
            mes_pkg::ACT_CTRL14:
            begin
                status_hi         = mes_pkg::ST_CTRL;
                has_status        = 1'b1;
                desc.msg_bytes[1] = {3'b000, cc_num};
                desc.msg_bytes[2] = {1'b0, value_b[13:7]};
                desc.msg_bytes[3] = {3'b001, cc_num};
                desc.msg_bytes[4] = {1'b0, value_b[6:0]};
                desc.last_idx     = 4'd4;
            end
            mes_pkg::ACT_NRPN, mes_pkg::ACT_RPN:
            begin
                status_hi         = mes_pkg::ST_CTRL;
                has_status        = 1'b1;
                desc.msg_bytes[1] = (action == mes_pkg::ACT_NRPN) ? mes_pkg::CC_NRPN_MSB
                                                                  : mes_pkg::CC_RPN_MSB;
                desc.msg_bytes[2] = {1'b0, value_a[13:7]};
                desc.msg_bytes[3] = (action == mes_pkg::ACT_NRPN) ? mes_pkg::CC_NRPN_LSB
                                                                  : mes_pkg::CC_RPN_LSB;
                desc.msg_bytes[4] = {1'b0, value_a[6:0]};
                desc.msg_bytes[5] = mes_pkg::CC_DATA_MSB;
                desc.msg_bytes[6] = {1'b0, value_b[13:7]};
                desc.msg_bytes[7] = mes_pkg::CC_DATA_LSB;
                desc.msg_bytes[8] = {1'b0, value_b[6:0]};
                desc.last_idx     = 4'd8;
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase
        // Place the status byte and skip it when running status allows
        if (has_status)
        begin
            desc.msg_bytes[0]   = status;
            desc.first_idx      = (rs_enable_reg && running_status_reg == status) ? 4'd1
                                                                                  : 4'd0;
            running_status_next = status;
        end
    end

    // Hold configuration and running status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_enable_reg      <= 1'b0;
            running_status_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                rs_enable_reg <= cfg_data;
            end
            if (accept)
            begin
                running_status_reg <= running_status_next;
            end
        end
    end

endmodule

// ===== src/mes_queue.sv =====
// Two-entry descriptor queue between the front end and the byte sender.
// Depends on mes_pkg for the descriptor type and depth.
module mes_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mes_pkg::msg_desc_t wr_desc,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output mes_pkg::msg_desc_t head
);

    mes_pkg::msg_desc_t              entries_reg [mes_pkg::QUEUE_DEPTH];
    logic [mes_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [mes_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [mes_pkg::QUEUE_AW:0]      count_reg;
    logic [mes_pkg::QUEUE_AW:0]      count_next;

    assign full       = (count_reg == (mes_pkg::QUEUE_AW + 1)'(mes_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store descriptors
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/mes_back.sv =====
// Back end: walks the head descriptor and sends one wire byte per cycle while out_ready is high.
// Depends on mes_pkg; reads from mes_queue and drives the output register.
module mes_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  mes_pkg::msg_desc_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic [7:0]         out_port,
    output logic               last_byte
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_port_reg;
    logic       last_byte_reg;
    logic       active_reg;
    logic [3:0] idx_reg;
    logic [3:0] cur_idx;
    logic       is_last;
    logic       load;

    assign cur_idx   = active_reg ? idx_reg : head.first_idx;
    assign is_last   = (cur_idx == head.last_idx);
    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign pop       = load && is_last;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_port  = out_port_reg;
    assign last_byte = last_byte_reg;

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= head.msg_bytes[cur_idx];
            out_port_reg  <= head.port;
            last_byte_reg <= is_last;
        end
    end

    // Advance through the message, drop it after its last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                active_reg    <= !is_last;
                idx_reg       <= cur_idx + 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/midi_event_serializer.sv =====
// Top level of the MIDI event serializer: front end, descriptor queue, byte sender.
// Depends on mes_pkg, mes_front, mes_queue, mes_back and midi_event_serializer_assert.svh.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_ready | action, channel, port_number, value_a,
//          |           |                     | value_b, payload_byte, first/last_of_message
//  out     | output    | out_valid/out_ready | out_byte, out_port, last_byte
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data (running status enable)
//
// An event makes 0 to 9 wire bytes, sent one per cycle while out_ready is high through the
// single byte register of the back end, after its descriptor is registered in the queue.
// The front end takes a new event every cycle while the two-entry queue has room.
// Events that make no bytes are taken and leave no trace but the cycle.
// Reset clears running status, its enable, the queue and the output valid flag.
`include "midi_event_serializer_assert.svh"

module midi_event_serializer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  action,
    input  logic [3:0]  channel,
    input  logic [7:0]  port_number,
    input  logic [13:0] value_a,
    input  logic [13:0] value_b,
    input  logic [7:0]  payload_byte,
    input  logic        first_of_message,
    input  logic        last_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [7:0]  out_port,
    output logic        last_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic               q_full;
    logic               push;
    logic               pop;
    logic               head_valid;
    mes_pkg::msg_desc_t wr_desc;
    mes_pkg::msg_desc_t head;

    // Classify incoming events
    mes_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .channel          (channel),
        .port_number      (port_number),
        .value_a          (value_a),
        .value_b          (value_b),
        .payload_byte     (payload_byte),
        .first_of_message (first_of_message),
        .last_of_message  (last_of_message),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .q_full           (q_full),
        .push             (push),
        .desc             (wr_desc)
    );

    // Buffer descriptors
    mes_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_desc    (wr_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Send bytes
    mes_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_port   (out_port),
        .last_byte  (last_byte)
    );

    // Dropped and unused codes never reach the queue
    `MES_ASSERT_SAME(a_drop_no_push, in_valid && in_ready && action >= mes_pkg::ACT_DROP, !push)
    // The queue only fills from an accepted item
    `MES_ASSERT_SAME(a_push_on_accept, push, in_valid && in_ready)
    // Retiring a descriptor loads its final byte
    `MES_ASSERT_NEXT(a_pop_marks_last, pop, out_valid && last_byte)
    // Nothing is sent while the queue is empty and the output is idle
    `MES_ASSERT_NEXT(a_no_phantom, !head_valid && !out_valid, !out_valid)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for midi_event_serializer: directed table, then random events.
// Depends on mes_pkg and the serializer RTL; predicts wire bytes and running status itself.
module tb;

    localparam int CYCLE_LIMIT   = 40000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 58;

    // Real-time wire bytes, in action order from the clock action up
    localparam logic [7:0] RT_BYTES [7] = '{8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hF6, 8'hFE, 8'hFF};

    typedef enum logic [1:0] {
        CFG_KEEP,
        CFG_RS_OFF,
        CFG_RS_ON
    } cfg_op_t;

    // One stimulus row; typed_bytes holds up to three bytes left-aligned
    typedef struct packed {
        cfg_op_t     cfg_op;
        logic [4:0]  action;
        logic [3:0]  channel;
        logic [7:0]  port_number;
        logic [13:0] value_a;
        logic [13:0] value_b;
        logic [7:0]  payload_byte;
        logic        first_of_message;
        logic        last_of_message;
        logic [1:0]  n_typed;
        logic [23:0] typed_bytes;
    } midi_event_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] port;
        logic       last;
    } wire_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [4:0]  action = '0;
    logic [3:0]  channel = '0;
    logic [7:0]  port_number = '0;
    logic [13:0] value_a = '0;
    logic [13:0] value_b = '0;
    logic [7:0]  payload_byte = '0;
    logic        first_of_message = 1'b0;
    logic        last_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic [7:0]  out_port;
    logic        last_byte;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    int          cycle_count = 0;
    int          mismatch_count = 0;
    int          send_idle_pct = 18;
    int          recv_idle_pct = 66;

    // Predictor state and its per-event output
    logic [7:0]  last_status = '0;
    logic        status_skip_en = 1'b0;
    logic [7:0]  event_bytes [$];
    wire_byte_t  wire_expect_q [$];
    midi_event_t directed_rows [$];

    midi_event_serializer i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .channel          (channel),
        .port_number      (port_number),
        .value_a          (value_a),
        .value_b          (value_b),
        .payload_byte     (payload_byte),
        .first_of_message (first_of_message),
        .last_of_message  (last_of_message),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_byte         (out_byte),
        .out_port         (out_port),
        .last_byte        (last_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always #4 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, wire_expect_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Send a channel status byte unless running status lets it drop
    function automatic void put_status(input logic [3:0] hi, input logic [3:0] ch);
        logic [7:0] status;
        status = {hi, ch};
        if (!(status_skip_en && last_status == status))
            event_bytes.push_back(status);
        last_status = status;
    endfunction

    // Work out the wire bytes of one event and advance running status
    function automatic void predict_wire(input midi_event_t ev);
        logic [4:0] ctl;
        logic [3:0] hi;
        event_bytes.delete();
        unique case (ev.action)
            mes_pkg::ACT_KEYON, mes_pkg::ACT_KEYOFF, mes_pkg::ACT_POLYPRESS,
            mes_pkg::ACT_CTRL, mes_pkg::ACT_BEND:
            begin
                unique case (ev.action)
                    mes_pkg::ACT_KEYON:     hi = mes_pkg::ST_NOTE_ON;
                    mes_pkg::ACT_KEYOFF:    hi = mes_pkg::ST_NOTE_OFF;
                    mes_pkg::ACT_POLYPRESS: hi = mes_pkg::ST_POLY;
                    mes_pkg::ACT_CTRL:      hi = mes_pkg::ST_CTRL;
                    default:                hi = mes_pkg::ST_BEND;
                endcase
                put_status(hi, ev.channel);
                event_bytes.push_back({1'b0, ev.value_a[6:0]});
                event_bytes.push_back({1'b0, ev.value_b[6:0]});
            end
            mes_pkg::ACT_PROG, mes_pkg::ACT_CHANPRESS:
            begin
                put_status(ev.action == mes_pkg::ACT_PROG ? mes_pkg::ST_PROG
                                                          : mes_pkg::ST_CHANPRESS,
                           ev.channel);
                event_bytes.push_back({1'b0, ev.value_a[6:0]});
            end
            mes_pkg::ACT_SONGPOS:
            begin
                event_bytes.push_back(mes_pkg::SYS_SONGPOS);
                event_bytes.push_back({1'b0, ev.value_a[6:0]});
                event_bytes.push_back({1'b0, ev.value_b[6:0]});
                last_status = '0;
            end
            mes_pkg::ACT_SONGSEL:
            begin
                event_bytes.push_back(mes_pkg::SYS_SONGSEL);
                event_bytes.push_back({1'b0, ev.value_a[6:0]});
                last_status = '0;
            end
            mes_pkg::ACT_RT_CLOCK, mes_pkg::ACT_RT_START, mes_pkg::ACT_RT_CONT,
            mes_pkg::ACT_RT_STOP, mes_pkg::ACT_RT_TUNE, mes_pkg::ACT_RT_SENSE,
            mes_pkg::ACT_RT_RESET:
                event_bytes.push_back(RT_BYTES[ev.action - mes_pkg::ACT_RT_CLOCK]);
            mes_pkg::ACT_SYSEX:
            begin
                last_status = '0;
                if (ev.first_of_message)
                    event_bytes.push_back(mes_pkg::SYS_SOX);
                event_bytes.push_back(ev.payload_byte);
                if (ev.last_of_message)
                    event_bytes.push_back(mes_pkg::SYS_EOX);
            end
            mes_pkg::ACT_STREAM:
            begin
                last_status = '0;
                event_bytes.push_back(ev.payload_byte);
            end
            mes_pkg::ACT_QFRAME:
            begin
                event_bytes.push_back(mes_pkg::SYS_QFRAME);
                event_bytes.push_back({1'b0, ev.value_a[2:0], ev.value_b[3:0]});
                last_status = '0;
            end
            mes_pkg::ACT_CTRL14:
            begin
                ctl = ev.value_a[4:0];
                put_status(mes_pkg::ST_CTRL, ev.channel);
                event_bytes.push_back({3'b000, ctl});
                event_bytes.push_back({1'b0, ev.value_b[13:7]});
                event_bytes.push_back({3'b001, ctl});
                event_bytes.push_back({1'b0, ev.value_b[6:0]});
            end
            mes_pkg::ACT_NRPN, mes_pkg::ACT_RPN:
            begin
                put_status(mes_pkg::ST_CTRL, ev.channel);
                event_bytes.push_back(ev.action == mes_pkg::ACT_NRPN ? mes_pkg::CC_NRPN_MSB
                                                                     : mes_pkg::CC_RPN_MSB);
                event_bytes.push_back({1'b0, ev.value_a[13:7]});
                event_bytes.push_back(ev.action == mes_pkg::ACT_NRPN ? mes_pkg::CC_NRPN_LSB
                                                                     : mes_pkg::CC_RPN_LSB);
                event_bytes.push_back({1'b0, ev.value_a[6:0]});
                event_bytes.push_back(mes_pkg::CC_DATA_MSB);
                event_bytes.push_back({1'b0, ev.value_b[13:7]});
                event_bytes.push_back(mes_pkg::CC_DATA_LSB);
                event_bytes.push_back({1'b0, ev.value_b[6:0]});
            end
            default:
            begin
                // drop and unused codes: nothing out, state kept
            end
        endcase
    endfunction

    function automatic midi_event_t midi_row(input cfg_op_t op, input logic [4:0] act,
                                             input logic [3:0] ch, input logic [7:0] port,
                                             input logic [13:0] va, input logic [13:0] vb,
                                             input logic [7:0] pay, input logic first,
                                             input logic last, input logic [1:0] n_typed,
                                             input logic [23:0] typed);
        midi_event_t ev;
        ev = '{op, act, ch, port, va, vb, pay, first, last, n_typed, typed};
        return ev;
    endfunction

    // Present one event, hold it until taken, then queue its bytes
    task automatic send_event(input midi_event_t ev);
        wire_byte_t entry;
        int         k;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        action           <= ev.action;
        channel          <= ev.channel;
        port_number      <= ev.port_number;
        value_a          <= ev.value_a;
        value_b          <= ev.value_b;
        payload_byte     <= ev.payload_byte;
        first_of_message <= ev.first_of_message;
        last_of_message  <= ev.last_of_message;
        do @(posedge clk); while (!in_ready);
        predict_wire(ev);
        if (ev.n_typed != 0)
        begin
            event_bytes.delete();
            for (k = 0; k < ev.n_typed; k++)
                event_bytes.push_back(ev.typed_bytes[23 - 8 * k -: 8]);
        end
        for (k = 0; k < event_bytes.size(); k++)
        begin
            entry.data = event_bytes[k];
            entry.port = ev.port_number;
            entry.last = (k == event_bytes.size() - 1);
            wire_expect_q.push_back(entry);
        end
    endtask

    // Wait until every queued byte is out and the block has gone quiet
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (wire_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rs_enable(input logic en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid      <= 1'b0;
        status_skip_en = en;
    endtask

    // Random events: channel messages with repeated status, framed sysex runs and other codes
    task automatic run_random(input int n_items);
        midi_event_t ev;
        int          made;
        int          sysex_left;
        int          pick;
        logic [4:0]  prev_act;
        logic [3:0]  prev_chan;
        made       = 0;
        sysex_left = 0;
        prev_act   = mes_pkg::ACT_KEYON;
        prev_chan  = '0;
        while (made < n_items)
        begin
            ev.cfg_op           = CFG_KEEP;
            ev.channel          = 4'($urandom_range(15));
            ev.port_number      = 8'($urandom_range(255));
            ev.value_a          = 14'($urandom_range(16383));
            ev.value_b          = 14'($urandom_range(16383));
            ev.payload_byte     = 8'($urandom_range(255));
            ev.first_of_message = 1'($urandom_range(1));
            ev.last_of_message  = 1'($urandom_range(1));
            ev.n_typed          = '0;
            ev.typed_bytes      = '0;
            pick = $urandom_range(99);
            if (sysex_left > 0)
            begin
                ev.action           = mes_pkg::ACT_SYSEX;
                ev.first_of_message = 1'b0;
                ev.last_of_message  = (sysex_left == 1);
                sysex_left--;
            end
            else if (pick < 10)
            begin
                sysex_left          = $urandom_range(5);
                ev.action           = mes_pkg::ACT_SYSEX;
                ev.first_of_message = 1'b1;
                ev.last_of_message  = (sysex_left == 0);
            end
            else if (pick < 45)
            begin
                ev.action  = prev_act;
                ev.channel = prev_chan;
            end
            else if (pick < 92)
                ev.action = 5'($urandom_range(int'(mes_pkg::ACT_RPN)));
            else
                ev.action = 5'($urandom_range(31, int'(mes_pkg::ACT_DROP)));
            if (ev.action <= mes_pkg::ACT_BEND ||
                (ev.action >= mes_pkg::ACT_CTRL14 && ev.action <= mes_pkg::ACT_RPN))
            begin
                prev_act  = ev.action;
                prev_chan = ev.channel;
            end
            send_event(ev);
            made++;
        end
    endtask

    // Check each output byte against the oldest expectation; randomize ready
    always @(posedge clk)
    begin : check_out
        wire_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (wire_expect_q.size() == 0)
                report_mismatch($sformatf("unexpected byte %h port %h last %b",
                                          out_byte, out_port, last_byte));
            else
            begin
                want = wire_expect_q.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.data));
                if (out_port !== want.port)
                    report_mismatch($sformatf("out_port %h, expected %h", out_port, want.port));
                if (last_byte !== want.last)
                    report_mismatch($sformatf("last_byte %b, expected %b", last_byte, want.last));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        // Extremes and every operation; running status off from reset, then on
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_KEYON, 4'd0, 8'h00,
            14'h0000, 14'h0000, 8'h00, 1'b0, 1'b0, 2'd3, 24'h90_00_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_KEYON, 4'd0, 8'hFF,
            14'h3FFF, 14'h3FFF, 8'hFF, 1'b1, 1'b1, 2'd3, 24'h90_7F_7F));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_KEYOFF, 4'd15, 8'h5A,
            14'h0080, 14'h007F, 8'h00, 1'b0, 1'b0, 2'd3, 24'h8F_00_7F));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_POLYPRESS, 4'd7, 8'hA5,
            14'h1234, 14'h2ABC, 8'h00, 1'b0, 1'b0, 2'd0, 24'h0));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_PROG, 4'd3, 8'h01,
            14'h3FFF, 14'h3FFF, 8'h00, 1'b0, 1'b0, 2'd2, 24'hC3_7F_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_SONGPOS, 4'd9, 8'h02,
            14'h3FFF, 14'h2A80, 8'h00, 1'b0, 1'b0, 2'd3, 24'hF2_7F_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_SYSEX, 4'd0, 8'h03,
            14'h0000, 14'h0000, 8'h00, 1'b1, 1'b0, 2'd2, 24'hF0_00_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_SYSEX, 4'd0, 8'h03,
            14'h0000, 14'h0000, 8'hFF, 1'b0, 1'b1, 2'd2, 24'hFF_F7_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_RT_CLOCK, 4'd1, 8'h10,
            14'h0, 14'h0, 8'h00, 1'b0, 1'b0, 2'd1, 24'hF8_00_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_RT_START, 4'd2, 8'h11,
            14'h0, 14'h0, 8'h00, 1'b0, 1'b0, 2'd1, 24'hFA_00_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_RT_CONT, 4'd3, 8'h12,
            14'h0, 14'h0, 8'h00, 1'b0, 1'b0, 2'd1, 24'hFB_00_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_RT_STOP, 4'd4, 8'h13,
            14'h0, 14'h0, 8'h00, 1'b0, 1'b0, 2'd1, 24'hFC_00_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_RT_TUNE, 4'd5, 8'h14,
            14'h0, 14'h0, 8'h00, 1'b0, 1'b0, 2'd1, 24'hF6_00_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_RT_SENSE, 4'd6, 8'h15,
            14'h0, 14'h0, 8'h00, 1'b0, 1'b0, 2'd1, 24'hFE_00_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_RT_RESET, 4'd7, 8'h16,
            14'h0, 14'h0, 8'h00, 1'b0, 1'b0, 2'd1, 24'hFF_00_00));
        directed_rows.push_back(midi_row(CFG_RS_ON, mes_pkg::ACT_CTRL, 4'd9, 8'h20,
            14'h0107, 14'h3F40, 8'h00, 1'b0, 1'b0, 2'd0, 24'h0));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_CTRL14, 4'd9, 8'h21,
            14'h3FFF, 14'h3FFF, 8'h00, 1'b0, 1'b0, 2'd0, 24'h0));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_NRPN, 4'd9, 8'h22,
            14'h2A55, 14'h15AA, 8'h00, 1'b0, 1'b0, 2'd0, 24'h0));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_SONGSEL, 4'd9, 8'h23,
            14'h3F85, 14'h0000, 8'h00, 1'b0, 1'b0, 2'd2, 24'hF3_05_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_RPN, 4'd9, 8'h24,
            14'h0000, 14'h3FFF, 8'h00, 1'b0, 1'b0, 2'd0, 24'h0));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_CHANPRESS, 4'd9, 8'h25,
            14'h00FF, 14'h0000, 8'h00, 1'b0, 1'b0, 2'd0, 24'h0));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_CHANPRESS, 4'd9, 8'h26,
            14'h0001, 14'h0000, 8'h00, 1'b0, 1'b0, 2'd0, 24'h0));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_STREAM, 4'd9, 8'h27,
            14'h0000, 14'h0000, 8'hAA, 1'b1, 1'b1, 2'd0, 24'h0));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_BEND, 4'd13, 8'h28,
            14'h2000, 14'h1FFF, 8'h00, 1'b0, 1'b0, 2'd0, 24'h0));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_QFRAME, 4'd13, 8'h29,
            14'h3FFF, 14'h3FFF, 8'h00, 1'b0, 1'b0, 2'd2, 24'hF1_7F_00));
        directed_rows.push_back(midi_row(CFG_KEEP, mes_pkg::ACT_DROP, 4'd15, 8'hFF,
            14'h3FFF, 14'h3FFF, 8'hFF, 1'b1, 1'b1, 2'd0, 24'h0));

        // Hold reset, then release it
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg_op != CFG_KEEP)
            begin
                settle_idle();
                write_rs_enable(directed_rows[i].cfg_op == CFG_RS_ON);
            end
            send_event(directed_rows[i]);
        end

        // Random phases: sender idles lightly, then heavily, then not at all
        settle_idle();
        write_rs_enable(1'b1);
        run_random(PHASE_ITEMS);

        settle_idle();
        send_idle_pct = 66;
        recv_idle_pct = 18;
        write_rs_enable(1'b0);
        run_random(PHASE_ITEMS);

        settle_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_rs_enable(1'b1);
        run_random(PHASE_ITEMS);

        settle_idle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
